[rtl/rotation_matrix_from_unit_vectors_defines.svh]
`ifndef ROTATION_MATRIX_FROM_UNIT_VECTORS_DEFINES_SVH
`define ROTATION_MATRIX_FROM_UNIT_VECTORS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RMUV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RMUV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rmuv_pkg.sv]
`default_nettype none
package rmuv_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int VEC_W      = 32;
  localparam int IN_W       = 6 * VEC_W;
  localparam int OUT_W      = 9 * VEC_W;
  localparam int CFG_W      = 31;
  localparam int DEN_W      = 34;
  localparam int NUM_W      = 62;
  localparam int QUO_W      = 32;
  localparam int CMP_W      = DEN_W + QUO_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int LANES      = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic signed [VEC_W-1:0] LIM = VEC_W'(64'sd1 <<< FRAC_BITS);
  localparam logic [QUO_W:0] QUO_CAP = {1'b1, {QUO_W{1'b0}}};
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // divider lanes
  localparam int LANE_P01 = 0;
  localparam int LANE_P02 = 1;
  localparam int LANE_P12 = 2;
  localparam int LANE_D0  = 3;
  localparam int LANE_D1  = 4;
  localparam int LANE_D2  = 5;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [QUO_W:0]   quo_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] v0;
    logic signed [VEC_W-1:0] v1;
    logic signed [VEC_W-1:0] v2;
    logic [DEN_W-1:0]        d;
    logic                    degenerate;
  } work_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] v0;
    logic signed [VEC_W-1:0] v1;
    logic signed [VEC_W-1:0] v2;
    logic                    degenerate;
    logic [2:0]              neg;
  } side_t;

endpackage
`default_nettype wire

[rtl/rmuv_front.sv]
`default_nettype none
module rmuv_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rmuv_pkg::IN_W-1:0]   in_data,
  input  wire logic [rmuv_pkg::CFG_W-1:0]  min_den,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rmuv_pkg::work_t                  out_word
);
  import rmuv_pkg::*;

  function automatic logic signed [VEC_W+1:0] rshift(input logic signed [63:0] x);
    logic signed [VEC_W+1:0] q;
    q = $signed((VEC_W+2)'(x >>> FRAC_BITS));
    return q + $signed({{(VEC_W+1){1'b0}}, x[FRAC_BITS-1]});
  endfunction

  function automatic logic signed [VEC_W-1:0] clampv(input logic signed [VEC_W+1:0] x);
    logic signed [VEC_W+1:0] hi;
    hi = {{2{LIM[VEC_W-1]}}, LIM};
    if (x > hi) return LIM;
    if (x < -hi) return -LIM;
    return VEC_W'(x);
  endfunction

  logic en;
  logic signed [VEC_W-1:0] ax, ay, az, bx, by, bz;

  logic f1_valid, f2_valid;
  logic signed [63:0] px1, px2, py1, py2, pz1, pz2, pd0, pd1, pd2;
  logic signed [VEC_W-1:0] v0, v1, v2;
  logic signed [DEN_W+1:0] dsum;
  logic signed [VEC_W+1:0] rd0, rd1, rd2;

  assign ax = $signed(in_data[VEC_W-1:0]);
  assign ay = $signed(in_data[2*VEC_W-1:VEC_W]);
  assign az = $signed(in_data[3*VEC_W-1:2*VEC_W]);
  assign bx = $signed(in_data[4*VEC_W-1:3*VEC_W]);
  assign by = $signed(in_data[5*VEC_W-1:4*VEC_W]);
  assign bz = $signed(in_data[6*VEC_W-1:5*VEC_W]);

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign rd0 = rshift(pd0);
  assign rd1 = rshift(pd1);
  assign rd2 = rshift(pd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid  <= in_valid;
      f2_valid  <= f1_valid;
      out_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cross and dot products
      px1 <= ay * bz;
      px2 <= az * by;
      py1 <= az * bx;
      py2 <= ax * bz;
      pz1 <= ax * by;
      pz2 <= ay * bx;
      pd0 <= ax * bx;
      pd1 <= ay * by;
      pd2 <= az * bz;
      // v and d = 1 + c
      v0   <= clampv(rshift(px1 - px2));
      v1   <= clampv(rshift(py1 - py2));
      v2   <= clampv(rshift(pz1 - pz2));
      dsum <= {{2{rd0[VEC_W+1]}}, rd0} + {{2{rd1[VEC_W+1]}}, rd1}
            + {{2{rd2[VEC_W+1]}}, rd2} + {{(DEN_W+2-VEC_W){1'b0}}, LIM};
      // classify
      out_word.v0 <= v0;
      out_word.v1 <= v1;
      out_word.v2 <= v2;
      out_word.d  <= dsum[DEN_W-1:0];
      out_word.degenerate <= (dsum <= 0)
                          || (dsum < $signed({{(DEN_W+2-CFG_W){1'b0}}, min_den}));
    end
  end

endmodule
`default_nettype wire

[rtl/rmuv_fifo.sv]
`default_nettype none
module rmuv_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rmuv_pkg::work_t  in_word,
  output logic                  full,
  input  wire logic             pop,
  output rmuv_pkg::work_t       out_word,
  output logic                  empty
);
  import rmuv_pkg::*;

  work_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign out_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
  end

endmodule
`default_nettype wire

[rtl/rmuv_div.sv]
`default_nettype none
module rmuv_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [rmuv_pkg::DEN_W-1:0]          in_d,
  input  wire rmuv_pkg::num_t [rmuv_pkg::LANES-1:0] in_num,
  input  wire rmuv_pkg::side_t                     in_side,
  output logic                                     out_valid,
  output rmuv_pkg::quo_t [rmuv_pkg::LANES-1:0]     out_q,
  output rmuv_pkg::side_t                          out_side
);
  import rmuv_pkg::*;

  logic               vld  [DIV_STEPS+1];
  logic [DEN_W-1:0]   dd   [DIV_STEPS+1];
  side_t              side [DIV_STEPS+1];
  logic [LANES-1:0]   ovf  [DIV_STEPS+1];
  num_t               rem  [DIV_STEPS+1][LANES];
  logic [QUO_W-1:0]   quo  [DIV_STEPS+1][LANES];

  // first stage: a quotient of 2^32 or more saturates that lane's entry
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0]   <= in_d;
      side[0] <= in_side;
      for (int l = 0; l < LANES; l++) begin
        ovf[0][l] <= CMP_W'(in_num[l]) >= {in_d, {QUO_W{1'b0}}};
        rem[0][l] <= in_num[l];
        quo[0][l] <= '0;
      end
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int SH = DIV_STEPS - k;
    logic [CMP_W-1:0]  dsh;
    logic [LANES-1:0]  ge;
    num_t              rem_n [LANES];
    logic [QUO_W-1:0]  quo_n [LANES];

    always_comb begin
      dsh = CMP_W'(dd[k-1]) << SH;
      for (int l = 0; l < LANES; l++) begin
        ge[l]        = CMP_W'(rem[k-1][l]) >= dsh;
        rem_n[l]     = ge[l] ? rem[k-1][l] - dsh[NUM_W-1:0] : rem[k-1][l];
        quo_n[l]     = quo[k-1][l];
        quo_n[l][SH] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[k]   <= dd[k-1];
        side[k] <= side[k-1];
        ovf[k]  <= ovf[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= rem_n[l];
          quo[k][l] <= quo_n[l];
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_side  = side[DIV_STEPS];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l] = ovf[DIV_STEPS][l] ? QUO_CAP : {1'b0, quo[DIV_STEPS][l]};
    end
  end

endmodule
`default_nettype wire

[rtl/rmuv_back.sv]
`default_nettype none
module rmuv_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_pop,
  input  wire rmuv_pkg::work_t              in_word,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rmuv_pkg::OUT_W-1:0]        out_data,
  output logic                              out_degenerate
);
  import rmuv_pkg::*;

  localparam int EW = QUO_W + 3;

  function automatic logic signed [VEC_W-1:0] sat(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] hi;
    hi = {{(EW-VEC_W){LIM[VEC_W-1]}}, LIM};
    if (x > hi) return LIM;
    if (x < -hi) return -LIM;
    return VEC_W'(x);
  endfunction

  function automatic logic signed [EW-1:0] vext(input logic signed [VEC_W-1:0] v);
    return {{(EW-VEC_W){v[VEC_W-1]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] qsgn(input quo_t q, input logic neg);
    logic signed [EW-1:0] m;
    m = $signed({{(EW-QUO_W-1){1'b0}}, q});
    return neg ? -m : m;
  endfunction

  logic en;

  logic               b1_valid;
  work_t              b1_word;
  logic signed [63:0] p01, p02, p12, sq0, sq1, sq2;

  logic               b2_valid;
  logic [DEN_W-1:0]   b2_d;
  side_t              b2_side;
  num_t [LANES-1:0]   b2_num;

  logic [NUM_W-1:0]   half;
  logic [2:0]         neg;
  logic [63:0]        mag01, mag02, mag12;

  logic               dv_valid;
  quo_t [LANES-1:0]   dv_q;
  side_t              dv_side;

  logic signed [EW-1:0] one_e, q01, q02, q12;

  assign en     = !out_valid || out_ready;
  assign in_pop = en && in_valid;

  // rounding: add half the divisor before dividing
  assign half  = {{(NUM_W-DEN_W+1){1'b0}}, b1_word.d[DEN_W-1:1]};
  assign neg   = {p12[63], p02[63], p01[63]};
  assign mag01 = p01[63] ? -p01 : p01;
  assign mag02 = p02[63] ? -p02 : p02;
  assign mag12 = p12[63] ? -p12 : p12;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= in_valid;
      b2_valid  <= b1_valid;
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_word <= in_word;
      p01 <= in_word.v0 * in_word.v1;
      p02 <= in_word.v0 * in_word.v2;
      p12 <= in_word.v1 * in_word.v2;
      sq0 <= in_word.v0 * in_word.v0;
      sq1 <= in_word.v1 * in_word.v1;
      sq2 <= in_word.v2 * in_word.v2;

      b2_d               <= b1_word.d;
      b2_side.v0         <= b1_word.v0;
      b2_side.v1         <= b1_word.v1;
      b2_side.v2         <= b1_word.v2;
      b2_side.degenerate <= b1_word.degenerate;
      b2_side.neg        <= neg;
      b2_num[LANE_P01]   <= mag01[NUM_W-1:0] + half;
      b2_num[LANE_P02]   <= mag02[NUM_W-1:0] + half;
      b2_num[LANE_P12]   <= mag12[NUM_W-1:0] + half;
      b2_num[LANE_D0]    <= NUM_W'(sq2 + sq1) + half;
      b2_num[LANE_D1]    <= NUM_W'(sq2 + sq0) + half;
      b2_num[LANE_D2]    <= NUM_W'(sq1 + sq0) + half;
    end
  end

  rmuv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b2_valid),
    .in_d      (b2_d),
    .in_num    (b2_num),
    .in_side   (b2_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  assign one_e = {{(EW-VEC_W){1'b0}}, LIM};
  assign q01   = qsgn(dv_q[LANE_P01], dv_side.neg[0]);
  assign q02   = qsgn(dv_q[LANE_P02], dv_side.neg[1]);
  assign q12   = qsgn(dv_q[LANE_P12], dv_side.neg[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_degenerate <= dv_side.degenerate;
      if (dv_side.degenerate) begin
        out_data <= {LIM, {(3*VEC_W){1'b0}}, LIM, {(3*VEC_W){1'b0}}, LIM};
      end else begin
        out_data <= {
          sat(one_e - qsgn(dv_q[LANE_D2], 1'b0)),
          sat(q12 + vext(dv_side.v0)),
          sat(q02 - vext(dv_side.v1)),
          sat(q12 - vext(dv_side.v0)),
          sat(one_e - qsgn(dv_q[LANE_D1], 1'b0)),
          sat(q01 + vext(dv_side.v2)),
          sat(q02 + vext(dv_side.v1)),
          sat(q01 - vext(dv_side.v2)),
          sat(one_e - qsgn(dv_q[LANE_D0], 1'b0))
        };
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rotation_matrix_from_unit_vectors.sv]
`default_nettype none
// Rodrigues rotation matrix that turns unit vector a onto unit vector b, all values signed
// Q1.30. One vector pair is taken every cycle and one matrix word leaves per cycle while
// the output is not stalled and the queue has room; the six quotients by 1 + a.b are formed
// by a pipelined restoring divider.
// When 1 + a.b falls below min_denominator (or is not positive) the identity is returned
// with tuser set. Entries saturate to +-1.0. Write min_denominator only while idle.
module rotation_matrix_from_unit_vectors (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z
  input  wire logic [rmuv_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic [rmuv_pkg::OUT_W-1:0]       m_axis_tdata,
  // degenerate
  output logic [0:0]                       m_axis_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [rmuv_pkg::CFG_W-1:0]  cfg_wdata
);
  import rmuv_pkg::*;

  `include "rotation_matrix_from_unit_vectors_defines.svh"

  logic [CFG_W-1:0] min_den;
  logic  f_valid, q_push, q_pop, q_full, q_empty;
  work_t f_word, q_word;

  always_ff @(posedge clk) begin
    if (rst) min_den <= CFG_RESET;
    else if (cfg_we) min_den <= cfg_wdata;
  end

  assign q_push = f_valid && !q_full;

  rmuv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .min_den   (min_den),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_word  (f_word)
  );

  rmuv_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .in_word  (f_word),
    .full     (q_full),
    .pop      (q_pop),
    .out_word (q_word),
    .empty    (q_empty)
  );

  rmuv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (!q_empty),
    .in_pop         (q_pop),
    .in_word        (q_word),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (m_axis_tdata),
    .out_degenerate (m_axis_tuser[0])
  );

  `RMUV_ASSERT_IMPL(a_degen_identity, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[VEC_W-1:0] == LIM && m_axis_tdata[2*VEC_W-1:VEC_W] == '0 && m_axis_tdata[5*VEC_W-1:4*VEC_W] == LIM && m_axis_tdata[9*VEC_W-1:8*VEC_W] == LIM, "degenerate word is not the identity")
  `RMUV_ASSERT_IMPL(a_stall_no_pop, m_axis_tvalid && !m_axis_tready, !q_pop, "queue read while output stalled")
  `RMUV_ASSERT_IMPL(a_ready_low_full, !s_axis_tready, q_full, "input stalled with room in queue")
  `RMUV_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full, "full queue changed without a read")

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import rmuv_pkg::*;

  localparam longint ONE = 64'sd1 << 30;
  localparam int N_RANDOM = 750;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  typedef struct {
    logic [OUT_W-1:0] mat;
    logic degen;
  } matrix_t;

  matrix_t pending_matrices[$];
  logic [CFG_W-1:0] min_den;
  int errors;
  int hold_cycles;
  bit rx_hold;
  bit busy_rx;
  bit send_gaps;

  rotation_matrix_from_unit_vectors dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint sat1(longint x);
    if (x > ONE) return ONE;
    if (x < -ONE) return -ONE;
    return x;
  endfunction

  // product scaled back by 2^30, round half up
  function automatic longint rescale(longint x);
    return (x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint quot(longint num, longint den);
    longint unsigned m, q;
    bit neg;
    neg = num < 0;
    m = neg ? -num : num;
    q = (m + den / 2) / den;
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic matrix_t rotation_of(logic [IN_W-1:0] w);
    matrix_t res;
    longint a[3], b[3], v[3], r[9], c, d;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(w[i*32 +: 32]));
      b[i] = longint'($signed(w[(i+3)*32 +: 32]));
    end
    v[0] = sat1(rescale(a[1] * b[2] - a[2] * b[1]));
    v[1] = sat1(rescale(a[2] * b[0] - a[0] * b[2]));
    v[2] = sat1(rescale(a[0] * b[1] - a[1] * b[0]));
    c = rescale(a[0] * b[0]) + rescale(a[1] * b[1]) + rescale(a[2] * b[2]);
    d = ONE + c;
    if (d <= 0 || d < longint'(min_den)) begin
      foreach (r[i]) r[i] = (i % 4 == 0) ? ONE : 0;
      res.degen = 1'b1;
    end else begin
      r[0] = sat1(ONE - quot(v[2] * v[2] + v[1] * v[1], d));
      r[1] = sat1(-v[2] + quot(v[0] * v[1], d));
      r[2] = sat1(v[1] + quot(v[0] * v[2], d));
      r[3] = sat1(v[2] + quot(v[0] * v[1], d));
      r[4] = sat1(ONE - quot(v[2] * v[2] + v[0] * v[0], d));
      r[5] = sat1(-v[0] + quot(v[1] * v[2], d));
      r[6] = sat1(-v[1] + quot(v[0] * v[2], d));
      r[7] = sat1(v[0] + quot(v[1] * v[2], d));
      r[8] = sat1(ONE - quot(v[1] * v[1] + v[0] * v[0], d));
      res.degen = 1'b0;
    end
    foreach (r[i]) res.mat[i*32 +: 32] = r[i][31:0];
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(longint ax, longint ay, longint az,
                                                longint bx, longint by, longint bz);
    return {bz[31:0], by[31:0], bx[31:0], az[31:0], ay[31:0], ax[31:0]};
  endfunction

  function automatic logic [31:0] rand_comp();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'(ONE);
    if (sel == 1) return 32'(-ONE);
    if (sel == 2) return $urandom;
    return $urandom_range(0, 2 * 32'h4000_0000) - 32'h4000_0000;
  endfunction

  // near-unit vector pairs with random angle, sometimes nearly opposite, now and then raw random words
  function automatic logic [IN_W-1:0] rand_pair();
    real ax, ay, az, bx, by, bz, n, s;
    logic [IN_W-1:0] w;
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 6; i++) w[i*32 +: 32] = rand_comp();
      return w;
    end
    ax = $urandom_range(0, 2000) - 1000.0;
    ay = $urandom_range(0, 2000) - 1000.0;
    az = $urandom_range(0, 2000) - 1000.0 + 0.5;
    n = $sqrt(ax * ax + ay * ay + az * az);
    ax /= n; ay /= n; az /= n;
    s = ($urandom_range(0, 3) == 0) ? 1.0e-4 * $urandom_range(0, 100) : 1.0;
    if ($urandom_range(0, 1)) begin
      bx = -ax + s * ($urandom_range(0, 200) - 100.0) / 100.0;
      by = -ay + s * ($urandom_range(0, 200) - 100.0) / 100.0;
      bz = -az + s * ($urandom_range(0, 200) - 100.0) / 100.0;
    end else begin
      bx = $urandom_range(0, 2000) - 1000.0;
      by = $urandom_range(0, 2000) - 1000.0;
      bz = $urandom_range(0, 2000) - 999.5;
    end
    n = $sqrt(bx * bx + by * by + bz * bz);
    bx /= n; by /= n; bz /= n;
    return pack_pair(longint'(ax * ONE), longint'(ay * ONE), longint'(az * ONE),
                     longint'(bx * ONE), longint'(by * ONE), longint'(bz * ONE));
  endfunction

  // valid stays high after the word so the next one can follow with no gap
  task automatic send_word(logic [IN_W-1:0] w, bit fixed = 1'b0,
                           logic [OUT_W-1:0] mat = '0, logic degen = 1'b0);
    matrix_t exp_m;
    if (send_gaps)
      while ($urandom_range(0, 99) < 37) begin
        s_axis_tvalid <= 0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (fixed) begin
      exp_m.mat = mat;
      exp_m.degen = degen;
      pending_matrices.push_back(exp_m);
    end else begin
      pending_matrices.push_back(rotation_of(w));
    end
  endtask

  task automatic set_min_den(logic [CFG_W-1:0] val);
    s_axis_tvalid <= 0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    min_den = val;
  endtask

  // receiver
  initial begin
    matrix_t exp_m;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_matrices.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_m = pending_matrices.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[i*32 +: 32] !== exp_m.mat[i*32 +: 32]) begin
              $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       exp_m.mat[i*32 +: 32], m_axis_tdata[i*32 +: 32]);
              errors++;
            end
          if (m_axis_tuser[0] !== exp_m.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_m.degen,
                     m_axis_tuser[0]);
            errors++;
          end
        end
      end
      if (rx_hold) begin
        // long back-pressure stretch, timed here in cycles
        m_axis_tready <= 0;
        hold_cycles++;
        if (hold_cycles >= 300) begin
          hold_cycles = 0;
          rx_hold = 0;
        end
      end
      else if (busy_rx) m_axis_tready <= ($urandom_range(0, 99) >= 37);
      else m_axis_tready <= 1;
    end
  end

  typedef struct {
    logic [IN_W-1:0] w;
    bit check;
    logic [OUT_W-1:0] mat;
    logic degen;
  } row_t;

  initial begin
    row_t rows[$];
    logic [OUT_W-1:0] ident;
    logic [CFG_W-1:0] cfgs[4];
    ident = '0;
    ident[0 +: 32] = ONE; ident[4*32 +: 32] = ONE; ident[8*32 +: 32] = ONE;
    errors = 0;
    hold_cycles = 0;
    rx_hold = 0;
    busy_rx = 1;
    send_gaps = 1;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    min_den = CFG_RESET;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // a = b: identity, not degenerate
    rows.push_back('{pack_pair(ONE, 0, 0, ONE, 0, 0), 1, ident, 0});
    // exactly opposite: identity flagged
    rows.push_back('{pack_pair(ONE, 0, 0, -ONE, 0, 0), 1, ident, 1});
    rows.push_back('{pack_pair(0, 0, -ONE, 0, 0, ONE), 1, ident, 1});
    rows.push_back('{pack_pair(0, ONE, 0, 0, ONE, 0), 1, ident, 0});
    rows.push_back('{pack_pair(ONE, 0, 0, 0, ONE, 0), 0, '0, 0});
    rows.push_back('{pack_pair(0, ONE, 0, 0, 0, ONE), 0, '0, 0});
    rows.push_back('{pack_pair(0, 0, ONE, ONE, 0, 0), 0, '0, 0});
    rows.push_back('{pack_pair(ONE, ONE, ONE, -ONE, ONE, -ONE), 0, '0, 0});
    rows.push_back('{pack_pair(-ONE, -ONE, -ONE, ONE, -ONE, ONE), 0, '0, 0});
    // all ones in every bit, and the most negative
    rows.push_back('{{6{32'hFFFF_FFFF}}, 0, '0, 0});
    rows.push_back('{{6{32'h8000_0000}}, 0, '0, 0});
    rows.push_back('{{3{32'h7FFF_FFFF, 32'h8000_0000}}, 0, '0, 0});
    rows.push_back('{pack_pair(ONE, 0, 0, -ONE + 2048, 46341, 0), 0, '0, 0});
    rows.push_back('{pack_pair(ONE, 0, 0, -ONE + 512, 23170, 0), 0, '0, 0});
    rows.push_back('{pack_pair(759250125, 759250125, 0, 0, 759250125, 759250125), 0, '0, 0});
    foreach (rows[i])
      send_word(rows[i].w, rows[i].check, rows[i].mat, rows[i].degen);

    cfgs = '{0, 31'h4000_0000, 31'h7FFF_FFFF, 31'd5_000_000};
    for (int ph = 0; ph < 4; ph++) begin
      set_min_den(cfgs[ph]);
      foreach (rows[i]) send_word(rows[i].w);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        if (ph == 1 && k == 20) rx_hold = 1;
        if (ph == 2) begin
          send_gaps = 0;
          busy_rx = 0;
        end else begin
          send_gaps = 1;
          busy_rx = 1;
        end
        send_word(rand_pair());
      end
    end
    set_min_den(CFG_RESET);
    for (int k = 0; k < N_RANDOM / 5; k++) send_word(rand_pair());

    s_axis_tvalid <= 0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/rmuv_pkg.sv
rtl/rmuv_front.sv
rtl/rmuv_fifo.sv
rtl/rmuv_div.sv
rtl/rmuv_back.sv
rtl/rotation_matrix_from_unit_vectors.sv
verif/testbench.sv
